@@ hdl/sha512_block_compression_defines.svh @@
// assertion macros for the sha-512 compression block
`ifndef SHA512_BLOCK_COMPRESSION_DEFINES_SVH
`define SHA512_BLOCK_COMPRESSION_DEFINES_SVH

`ifndef SYNTHESIS
`define S512C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define S512C_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define S512C_ASSERT(lbl, prop, msg)
`define S512C_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ hdl/s512c_pkg.sv @@
// shared constants, types and functions of the sha-512 compression block
`default_nettype none

package s512c_pkg;

  localparam int ROUND_COUNT = 80;
  localparam int BLOCK_WORDS = 16;
  localparam int CHAIN_WORDS = 8;
  localparam int WORD_W      = 64;
  localparam int CIDX_W      = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int WCNT_W      = 4;

  localparam logic [WORD_W-1:0] K_TABLE [ROUND_COUNT] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  typedef struct packed {
    logic load;
    logic start;
    logic prep;
    logic round;
    logic fold;
  } cmd_t;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
    big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
    big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
    small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
    small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

`default_nettype wire

@@ hdl/sha512_block_compression.sv @@
// sha-512 compression: 64-bit message words in, eight chaining words out per block
//
// input channel: in_valid / in_stall with in_message_word and in_start_message.
// words are taken one per cycle while the block is idle; in_start_message on a
// word reloads the chaining value from the init registers and makes that word
// the first of a new block. after the sixteenth word in_stall rises.
// compression: a setup state (S_PREP), the round state (one round per cycle on a
// single round unit) and a fold state that adds into the chaining value, so the
// first result is registered in the fold state and then shown from S_OUT.
// result channel: out_valid / out_stall with out_chain_word, out_word_index and
// out_last_word; eight requests in order, at most one per cycle. out_stall holds
// the current request; input is taken again once the eighth is delivered.
// configuration: cfg_we / cfg_index / cfg_wdata write init words 0..7; other
// indexes are ignored. writes apply at the next start of a message.
// reset (rst_n low, synchronous) clears the init registers, the chaining value,
// the word count and all control state.
`default_nettype none
`include "sha512_block_compression_defines.svh"

module sha512_block_compression #(
  parameter int ROUND_COUNT = s512c_pkg::ROUND_COUNT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [s512c_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [s512c_pkg::WORD_W-1:0]      cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [s512c_pkg::WORD_W-1:0]      in_message_word,
  input  wire logic                              in_start_message,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [s512c_pkg::WORD_W-1:0]           out_chain_word,
  output logic [s512c_pkg::CIDX_W-1:0]           out_word_index,
  output logic                                   out_last_word
);

  localparam int RND_W = $clog2(ROUND_COUNT);
  localparam logic [s512c_pkg::CIDX_W-1:0] IDX_LAST =
    s512c_pkg::CIDX_W'(s512c_pkg::CHAIN_WORDS - 1);

  s512c_pkg::cmd_t                 cmd;
  logic [RND_W-1:0]                rnd;
  logic [s512c_pkg::CIDX_W-1:0]    out_idx;

  s512c_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_start_message (in_start_message),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_idx          (out_idx),
    .cmd              (cmd),
    .rnd              (rnd)
  );

  s512c_datapath #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .rnd        (rnd),
    .msg_word   (in_message_word),
    .out_idx    (out_idx),
    .chain_word (out_chain_word)
  );

  assign out_word_index = out_idx;
  assign out_last_word  = (out_idx == IDX_LAST);

  `S512C_ASSERT(a_no_input_during_results, out_valid |-> in_stall, "input taken while results pending")
  `S512C_ASSERT(a_results_contiguous, (out_valid && !out_stall && !out_last_word) |=> out_valid, "result burst broken")
  `S512C_ASSERT(a_burst_ends, (out_valid && !out_stall && out_last_word) |=> !out_valid, "extra result after last word")
  `S512C_ASSERT(a_no_rounds_in_output, out_valid |-> (!cmd.round && !cmd.prep && !cmd.fold), "datapath busy during results")
  `S512C_ASSERT_RST(a_reset_clears_output, !rst_n |=> !out_valid, "result valid after reset")

endmodule

`default_nettype wire

@@ hdl/s512c_ctrl.sv @@
// controller: word counting, round sequencing and result handshake
`default_nettype none

module s512c_ctrl #(
  parameter int ROUND_COUNT = s512c_pkg::ROUND_COUNT,
  localparam int RND_W = $clog2(ROUND_COUNT)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_start_message,
  output logic                               in_stall,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [s512c_pkg::CIDX_W-1:0]       out_idx,
  output s512c_pkg::cmd_t                    cmd,
  output logic [RND_W-1:0]                   rnd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_t;

  localparam logic [s512c_pkg::WCNT_W-1:0] WC_LAST =
    s512c_pkg::WCNT_W'(s512c_pkg::BLOCK_WORDS - 1);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_COUNT - 1);
  localparam logic [s512c_pkg::CIDX_W-1:0] IDX_LAST =
    s512c_pkg::CIDX_W'(s512c_pkg::CHAIN_WORDS - 1);

  state_t                          state_r;
  logic [s512c_pkg::WCNT_W-1:0]    wcnt_r;
  logic [RND_W-1:0]                rnd_r;
  logic [s512c_pkg::CIDX_W-1:0]    idx_r;
  logic                            out_valid_r;
  logic                            in_acc;
  logic                            out_acc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_idx   = idx_r;
  assign rnd       = rnd_r;

  assign cmd.load  = in_acc;
  assign cmd.start = in_acc && in_start_message;
  assign cmd.prep  = (state_r == S_PREP);
  assign cmd.round = (state_r == S_ROUND);
  assign cmd.fold  = (state_r == S_FOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wcnt_r      <= '0;
      rnd_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_start_message) begin
              wcnt_r <= s512c_pkg::WCNT_W'(1);
            end else if (wcnt_r == WC_LAST) begin
              wcnt_r  <= '0;
              state_r <= S_PREP;
            end else begin
              wcnt_r <= wcnt_r + 1'b1;
            end
          end
        end
        S_PREP: begin
          rnd_r   <= '0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          if (rnd_r == RND_LAST) begin
            rnd_r   <= '0;
            state_r <= S_FOLD;
          end else begin
            rnd_r <= rnd_r + 1'b1;
          end
        end
        S_FOLD: begin
          idx_r       <= '0;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) begin
            if (idx_r == IDX_LAST) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/s512c_datapath.sv @@
// datapath: init registers, chaining value, schedule window and round logic
`default_nettype none

module s512c_datapath #(
  parameter int ROUND_COUNT = s512c_pkg::ROUND_COUNT,
  localparam int RND_W = $clog2(ROUND_COUNT)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [s512c_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [s512c_pkg::WORD_W-1:0]      cfg_wdata,
  input  wire s512c_pkg::cmd_t                   cmd,
  input  wire logic [RND_W-1:0]                  rnd,
  input  wire logic [s512c_pkg::WORD_W-1:0]      msg_word,
  input  wire logic [s512c_pkg::CIDX_W-1:0]      out_idx,
  output logic [s512c_pkg::WORD_W-1:0]           chain_word
);

  localparam int W  = s512c_pkg::WORD_W;
  localparam int CW = s512c_pkg::CHAIN_WORDS;
  localparam int BW = s512c_pkg::BLOCK_WORDS;

  logic [W-1:0] init_r  [CW];
  logic [W-1:0] chain_r [CW];
  logic [W-1:0] chain_nxt [CW];
  logic [W-1:0] var_r   [CW];
  logic [W-1:0] var_nxt [CW];
  logic [W-1:0] win_r   [BW];
  logic [W-1:0] win_nxt [BW];
  logic [W-1:0] hkw_r;
  logic [W-1:0] hkw_nxt;

  logic [W-1:0] sched_new;
  logic [W-1:0] push_word;
  logic [RND_W-1:0] k_idx;
  logic [W-1:0] k_val;
  logic [W-1:0] t1;
  logic [W-1:0] t2;
  logic [W-1:0] maj;
  logic [W-1:0] ch;

  // next schedule word from the rolling window
  assign sched_new = win_r[0] + s512c_pkg::small_sigma0(win_r[1]) + win_r[9]
                   + s512c_pkg::small_sigma1(win_r[14]);
  assign push_word = cmd.load ? msg_word : sched_new;

  // constant for the round that follows
  assign k_idx = cmd.prep ? '0 : RND_W'(rnd + 1'b1);
  assign k_val = (k_idx < RND_W'(ROUND_COUNT)) ? s512c_pkg::K_TABLE[k_idx] : '0;

  assign maj = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
  assign ch  = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
  assign t1  = hkw_r + s512c_pkg::big_sigma1(var_r[4]) + ch;
  assign t2  = s512c_pkg::big_sigma0(var_r[0]) + maj;

  always_comb begin
    for (int i = 0; i < BW - 1; i++) begin
      win_nxt[i] = win_r[i + 1];
    end
    win_nxt[BW-1] = push_word;

    chain_nxt = chain_r;
    if (cmd.start) begin
      chain_nxt = init_r;
    end else if (cmd.fold) begin
      for (int i = 0; i < CW; i++) begin
        chain_nxt[i] = chain_r[i] + var_r[i];
      end
    end

    var_nxt = var_r;
    hkw_nxt = hkw_r;
    if (cmd.prep) begin
      var_nxt = chain_r;
      hkw_nxt = chain_r[CW-1] + k_val + win_r[0];
    end else if (cmd.round) begin
      var_nxt[7] = var_r[6];
      var_nxt[6] = var_r[5];
      var_nxt[5] = var_r[4];
      var_nxt[4] = var_r[3] + t1;
      var_nxt[3] = var_r[2];
      var_nxt[2] = var_r[1];
      var_nxt[1] = var_r[0];
      var_nxt[0] = t1 + t2;
      hkw_nxt    = var_r[6] + k_val + win_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CW; i++) begin
        init_r[i]  <= '0;
        chain_r[i] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_index < s512c_pkg::CFG_IDX_W'(CW))) begin
        init_r[cfg_index[s512c_pkg::CIDX_W-1:0]] <= cfg_wdata;
      end
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.prep || cmd.round) begin
      win_r <= win_nxt;
    end
    var_r <= var_nxt;
    hkw_r <= hkw_nxt;
  end

  assign chain_word = chain_r[out_idx];

endmodule

`default_nettype wire
